// ===== src/bvt_pkg.sv =====
// Shared types for the bounded vector table: command and result beats,
// controller states, and the command/status bundles between control and datapath.
// No dependencies.
package bvt_pkg;

   // Command codes carried in the action field
   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_TOP    = 3'd2,
      ACT_GET    = 3'd3,
      ACT_INSERT = 3'd4,
      ACT_ERASE  = 3'd5,
      ACT_CLEAR  = 3'd6
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Input beat
   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  pos_first;
      logic [7:0]  pos_second;
      logic [8:0]  copies;
      logic [31:0] word_in;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [31:0] word_out;
      logic [1:0]  status;
      logic [8:0]  fill_count;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_UP,
      S_DOWN,
      S_FILL,
      S_FINISH
   } state_type;

   // Fill count updates
   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_ADD,
      CNT_SUB,
      CNT_CLR
   } count_op_type;

   // Controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         eval_latch;
      logic         push_write;
      logic         rd_issue;
      logic         word_capture;
      logic         up_start;
      logic         dn_start;
      logic         fill_start;
      logic         move_step;
      logic         fill_step;
      logic         rsp_load;
      count_op_type count_op;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       ok;
      logic [2:0] action;
      logic       copies_zero;
      logic       up_empty;
      logic       dn_empty;
      logic       move_done;
      logic       left_zero;
      logic       rsp_free;
   } stat_type;

endpackage

// ===== src/bvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bvt_ctrl.sv =====
// Sequencer for the bounded vector table: walks each command through check,
// read, shift and fill phases. Depends on bvt_pkg.
module bvt_ctrl
   import bvt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.count_op = CNT_HOLD;
      req_stall = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end

         S_CHECK: begin
            cmd.eval_latch = 1'b1;
            state_in       = S_FINISH;
            if (stat.ok) begin
               case (stat.action)
                  ACT_PUSH: begin
                     cmd.push_write = 1'b1;
                     cmd.count_op   = CNT_INC;
                  end
                  ACT_POP: begin
                     cmd.rd_issue = 1'b1;
                     cmd.count_op = CNT_DEC;
                     state_in     = S_READ;
                  end
                  ACT_TOP, ACT_GET: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_READ;
                  end
                  ACT_INSERT: begin
                     if (!stat.copies_zero) begin
                        if (stat.up_empty) begin
                           cmd.fill_start = 1'b1;
                           state_in       = S_FILL;
                        end else begin
                           cmd.up_start = 1'b1;
                           state_in     = S_UP;
                        end
                     end
                  end
                  ACT_ERASE: begin
                     if (stat.dn_empty) begin
                        cmd.count_op = CNT_SUB;
                     end else begin
                        cmd.dn_start = 1'b1;
                        state_in     = S_DOWN;
                     end
                  end
                  ACT_CLEAR: begin
                     cmd.count_op = CNT_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            cmd.word_capture = 1'b1;
            state_in         = S_FINISH;
         end

         // Tail moves up by the copy count, then the gap is filled
         S_UP: begin
            if (stat.move_done) begin
               cmd.fill_start = 1'b1;
               state_in       = S_FILL;
            end else begin
               cmd.move_step = 1'b1;
            end
         end

         // Tail moves down over the erased span
         S_DOWN: begin
            if (stat.move_done) begin
               cmd.count_op = CNT_SUB;
               state_in     = S_FINISH;
            end else begin
               cmd.move_step = 1'b1;
            end
         end

         S_FILL: begin
            if (stat.left_zero) begin
               cmd.count_op = CNT_ADD;
               state_in     = S_FINISH;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end

         // Hand the result to the output register once it is free
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/bvt_dpath.sv =====
// Datapath for the bounded vector table: request and count registers, bounds
// checks, move/fill address counters, entry RAM and result register.
// Depends on bvt_pkg and bvt_ram.
module bvt_dpath
   import bvt_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int WORD_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > 9) ? CW : 9) + 1;
   localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

   req_type         req_ff;
   logic [CW-1:0]   count_ff, count_in;
   status_type      st_ff, st_in;
   logic [31:0]     word_ff, word_in;
   logic [AW-1:0]   src_ff, src_in;
   logic [AW-1:0]   dst_ff, dst_in;
   logic [EW-1:0]   left_ff, left_in;
   logic            pend_ff, pend_in;
   logic            up_ff, up_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [EW-1:0]   cnt_e, first_e, second_e, copies_e;
   logic [EW-1:0]   lo_e, hi_e, hi_c, span_e;
   status_type      eval_st;
   logic [WORD_WIDTH-1:0] word_w;
   logic            rsp_free;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0] wr_data, rd_data;

   // Request beat capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // Operand widening and erase range
   always_comb begin
      cnt_e    = EW'(count_ff);
      first_e  = EW'(req_ff.pos_first);
      second_e = EW'(req_ff.pos_second);
      copies_e = EW'(req_ff.copies);
      lo_e     = (first_e < second_e) ? first_e : second_e;
      hi_e     = (first_e < second_e) ? second_e : first_e;
      hi_c     = (hi_e >= cnt_e) ? (cnt_e - EW'(1)) : hi_e;
      span_e   = hi_c - lo_e + EW'(1);
      word_w   = WORD_WIDTH'(req_ff.word_in);
   end

   // Bounds and capacity checks
   always_comb begin
      eval_st = ST_OK;
      case (req_ff.action)
         ACT_PUSH: begin
            if (cnt_e >= CAP_E) eval_st = ST_FULL;
         end
         ACT_POP, ACT_TOP: begin
            if (cnt_e == '0) eval_st = ST_RANGE;
         end
         ACT_GET: begin
            if (first_e >= cnt_e) eval_st = ST_RANGE;
         end
         ACT_INSERT: begin
            if (first_e > cnt_e) begin
               eval_st = ST_RANGE;
            end else if ((cnt_e + copies_e) > CAP_E) begin
               eval_st = ST_FULL;
            end
         end
         ACT_ERASE: begin
            if (lo_e >= cnt_e) eval_st = ST_RANGE;
         end
         default: begin
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Status toward the controller
   always_comb begin
      stat.ok          = (eval_st == ST_OK);
      stat.action      = req_ff.action;
      stat.copies_zero = (copies_e == '0);
      stat.up_empty    = (cnt_e == first_e);
      stat.dn_empty    = ((hi_c + EW'(1)) == cnt_e);
      stat.move_done   = (left_ff == '0) && !pend_ff;
      stat.left_zero   = (left_ff == '0);
      stat.rsp_free    = rsp_free;
   end

   // Next-state logic for counters, RAM ports and result
   always_comb begin
      count_in     = count_ff;
      st_in        = st_ff;
      word_in      = word_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      up_in        = up_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = dst_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = src_ff;

      if (cmd.eval_latch) begin
         st_in   = eval_st;
         word_in = '0;
      end

      // Push: store at the tail
      if (cmd.push_write) begin
         wr_en   = 1'b1;
         wr_addr = AW'(cnt_e);
         wr_data = word_w;
      end

      // Single read for pop, top and get
      if (cmd.rd_issue) begin
         rd_en   = 1'b1;
         rd_addr = (req_ff.action == ACT_GET) ? AW'(first_e) : AW'(cnt_e - EW'(1));
      end

      if (cmd.word_capture) begin
         word_in = 32'(rd_data);
      end

      // Move setup: up walks from the tail down, down walks from past the span up
      if (cmd.up_start) begin
         up_in   = 1'b1;
         src_in  = AW'(cnt_e - EW'(1));
         dst_in  = AW'(cnt_e - EW'(1) + copies_e);
         left_in = cnt_e - first_e;
         pend_in = 1'b0;
      end
      if (cmd.dn_start) begin
         up_in   = 1'b0;
         src_in  = AW'(hi_c + EW'(1));
         dst_in  = AW'(lo_e);
         left_in = cnt_e - hi_c - EW'(1);
         pend_in = 1'b0;
      end

      // Move step: read one entry, write the one read last cycle
      if (cmd.move_step) begin
         if (left_ff != '0) begin
            rd_en   = 1'b1;
            rd_addr = src_ff;
            src_in  = up_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
            left_in = left_ff - EW'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = rd_data;
            dst_in  = up_ff ? (dst_ff - AW'(1)) : (dst_ff + AW'(1));
         end
      end

      // Fill the opened gap with copies of the word
      if (cmd.fill_start) begin
         dst_in  = AW'(first_e);
         left_in = copies_e;
         pend_in = 1'b0;
      end
      if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = word_w;
         dst_in  = dst_ff + AW'(1);
         left_in = left_ff - EW'(1);
      end

      // Fill count update
      unique case (cmd.count_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = CW'(cnt_e + EW'(1));
         CNT_DEC:  count_in = CW'(cnt_e - EW'(1));
         CNT_ADD:  count_in = CW'(cnt_e + copies_e);
         CNT_SUB:  count_in = CW'(cnt_e - span_e);
         CNT_CLR:  count_in = '0;
         default:  count_in = count_ff;
      endcase

      // Output register
      if (cmd.rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.word_out    = word_ff;
         rsp_in.status      = st_ff;
         rsp_in.fill_count  = 9'(count_ff);
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      word_ff <= word_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      up_ff   <= up_in;
      rsp_ff  <= rsp_in;
   end

   bvt_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/bounded_vector_table_top.sv =====
// Bounded vector table with a registered result beat. Push, clear and rejected
// commands go from the check state to the finish state; pop, top and get pass
// through a read state first. Insert shifts entries up when entries move, then
// fills the copies; erase shifts the entries above the range down. A new request
// beat is taken in the cycle after the result loads, even while that result is
// stalled. Reset clears the count, move counters, state and result valid flag.
module bounded_vector_table_top
   import bvt_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int WORD_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   bvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bvt_dpath #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== dv/bounded_vector_table_top_tb.sv =====
// Testbench for bounded_vector_table_top: directed and random command beats,
// each result checked against an in-bench model of the table.
// Depends on bvt_pkg and bounded_vector_table_top.
module bounded_vector_table_top_tb;
   import bvt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;
   localparam int WIDTH = 32;
   localparam logic [2:0] ACT_RESERVED = 3'd7;  // unused action code
   localparam int DRAIN_GUARD = 5000;
   localparam int TAIL_CYCLES = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Table model and outstanding replies
   logic [WIDTH-1:0] table_words [DEPTH];
   int               live_count = 0;
   rsp_type          expected_replies [$];
   int               mismatch_total = 0;
   bit               idle_on = 1'b1;
   int               stall_left = 0;

   bounded_vector_table_top #(
      .CAPACITY   (DEPTH),
      .WORD_WIDTH (WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Watchdog
   initial begin
      #(40_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic log_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      mismatch_total++;
      $display("[%0t] MISMATCH %s: got %0h want %0h", $time, what, got, want);
   endtask

   // Apply one command to the table model, return the reply it produces
   function automatic rsp_type predict_reply(input req_type cmd);
      rsp_type r;
      int      lo;
      int      hi;
      int      span;
      r = '0;
      r.status = ST_OK;
      case (cmd.action)
         ACT_PUSH: begin
            if (live_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               table_words[live_count] = cmd.word_in;
               live_count++;
            end
         end
         ACT_POP, ACT_TOP: begin
            if (live_count == 0) begin
               r.status = ST_RANGE;
            end else begin
               r.word_out = table_words[live_count-1];
               if (cmd.action == ACT_POP) live_count--;
            end
         end
         ACT_GET: begin
            if (int'(cmd.pos_first) >= live_count) r.status = ST_RANGE;
            else r.word_out = table_words[cmd.pos_first];
         end
         ACT_INSERT: begin
            // position is checked before capacity
            if (int'(cmd.pos_first) > live_count) begin
               r.status = ST_RANGE;
            end else if (live_count + int'(cmd.copies) > DEPTH) begin
               r.status = ST_FULL;
            end else if (cmd.copies != 0) begin
               for (int i = live_count; i > int'(cmd.pos_first); i--)
                  table_words[i - 1 + int'(cmd.copies)] = table_words[i-1];
               for (int i = 0; i < int'(cmd.copies); i++)
                  table_words[int'(cmd.pos_first) + i] = cmd.word_in;
               live_count += int'(cmd.copies);
            end
         end
         ACT_ERASE: begin
            // ends ordered, high end clamped to the last entry
            lo = int'((cmd.pos_first < cmd.pos_second) ? cmd.pos_first : cmd.pos_second);
            hi = int'((cmd.pos_first < cmd.pos_second) ? cmd.pos_second : cmd.pos_first);
            if (lo >= live_count) begin
               r.status = ST_RANGE;
            end else begin
               if (hi >= live_count) hi = live_count - 1;
               span = hi - lo + 1;
               for (int i = hi + 1; i < live_count; i++)
                  table_words[i - span] = table_words[i];
               live_count -= span;
            end
         end
         ACT_CLEAR: live_count = 0;
         default: ;
      endcase
      if (r.status != ST_OK) r.word_out = '0;
      r.fill_count = live_count[8:0];
      return r;
   endfunction

   function automatic req_type make_cmd(input logic [2:0] act, input int first,
                                        input int second, input int copies,
                                        input logic [31:0] word);
      req_type cmd;
      cmd.action     = act;
      cmd.pos_first  = first[7:0];
      cmd.pos_second = second[7:0];
      cmd.copies     = copies[8:0];
      cmd.word_in    = word;
      return cmd;
   endfunction

   // Mostly well-formed commands aimed at the live part of the table
   function automatic req_type random_cmd();
      req_type cmd;
      int      pick;
      int      top_pos;
      int      lo;
      int      hi;
      cmd.action     = ACT_PUSH;
      cmd.pos_first  = 8'($urandom);
      cmd.pos_second = 8'($urandom);
      cmd.copies     = 9'($urandom_range(0, 256));
      cmd.word_in    = $urandom;
      top_pos = (live_count > 255) ? 255 : live_count;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         cmd.action = ACT_PUSH;
      end else if (pick < 40) begin
         cmd.action = ACT_POP;
      end else if (pick < 46) begin
         cmd.action = ACT_TOP;
      end else if (pick < 60) begin
         cmd.action = ACT_GET;
         if (live_count > 0 && $urandom_range(0, 7) != 0)
            cmd.pos_first = 8'($urandom_range(0, live_count - 1));
      end else if (pick < 74) begin
         cmd.action = ACT_INSERT;
         if ($urandom_range(0, 19) != 0) cmd.copies = 9'($urandom_range(0, 6));
         if ($urandom_range(0, 7) != 0) cmd.pos_first = 8'($urandom_range(0, top_pos));
      end else if (pick < 90) begin
         cmd.action = ACT_ERASE;
         if (live_count > 0 && $urandom_range(0, 7) != 0) begin
            lo = $urandom_range(0, live_count - 1);
            hi = lo + $urandom_range(0, 5);
            if (hi > 255) hi = 255;
            if ($urandom_range(0, 1) == 1) begin
               cmd.pos_first  = 8'(hi);
               cmd.pos_second = 8'(lo);
            end else begin
               cmd.pos_first  = 8'(lo);
               cmd.pos_second = 8'(hi);
            end
         end
      end else if (pick < 93) begin
         cmd.action = ACT_CLEAR;
      end else if (pick < 95) begin
         cmd.action = ACT_RESERVED;
      end
      return cmd;
   endfunction

   // Drive one command beat, hold it until taken, then record its reply
   task automatic send_cmd(input req_type cmd);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
      expected_replies.push_back(predict_reply(cmd));
   endtask

   // Stop sending and wait for every outstanding reply
   task automatic wait_for_drain();
      int guard;
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (expected_replies.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each taken result beat with the oldest expectation
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            log_mismatch("reply with none outstanding", rsp_data.word_out, '0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.word_out !== want.word_out)
               log_mismatch("word_out", rsp_data.word_out, want.word_out);
            if (rsp_data.status !== want.status)
               log_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.fill_count !== want.fill_count)
               log_mismatch("fill_count", 32'(rsp_data.fill_count),
                            32'(want.fill_count));
         end
      end
   end

   // Pop, top, get, erase and an out-of-range insert against an empty table
   task automatic test_empty_table();
      send_cmd(make_cmd(ACT_POP, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_TOP, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_GET, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_ERASE, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_INSERT, 1, 0, 3, 32'h1234_5678));
   endtask

   // Push, get bounds, insert and erase corner cases, reserved code, pop, clear
   task automatic test_basic_ops();
      send_cmd(make_cmd(ACT_PUSH, 0, 0, 0, 32'h0000_0000));
      send_cmd(make_cmd(ACT_PUSH, 0, 0, 0, 32'hFFFF_FFFF));
      send_cmd(make_cmd(ACT_PUSH, 0, 0, 0, 32'hA5A5_A5A5));
      send_cmd(make_cmd(ACT_GET, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_GET, 3, 0, 0, '0));
      send_cmd(make_cmd(ACT_INSERT, 1, 0, 0, 32'hDEAD_BEEF));
      send_cmd(make_cmd(ACT_INSERT, 1, 0, 2, 32'h5A5A_5A5A));
      send_cmd(make_cmd(ACT_INSERT, 255, 0, 1, 32'h0BAD_F00D));
      send_cmd(make_cmd(ACT_ERASE, 3, 1, 0, '0));
      send_cmd(make_cmd(ACT_RESERVED, 255, 255, 256, 32'hFFFF_FFFF));
      send_cmd(make_cmd(ACT_POP, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, '0));
   endtask

   // Fill to capacity in one insert, overflow attempts, clamped erases
   task automatic test_capacity();
      send_cmd(make_cmd(ACT_INSERT, 0, 0, 256, 32'hC0DE_0001));
      send_cmd(make_cmd(ACT_PUSH, 0, 0, 0, 32'h1111_1111));
      send_cmd(make_cmd(ACT_INSERT, 255, 0, 1, 32'h2222_2222));
      send_cmd(make_cmd(ACT_INSERT, 0, 0, 0, 32'h3333_3333));
      send_cmd(make_cmd(ACT_GET, 255, 0, 0, '0));
      send_cmd(make_cmd(ACT_POP, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_PUSH, 0, 0, 0, 32'h8000_0001));
      send_cmd(make_cmd(ACT_TOP, 0, 0, 0, '0));
      send_cmd(make_cmd(ACT_ERASE, 255, 255, 0, '0));
      send_cmd(make_cmd(ACT_ERASE, 255, 10, 0, '0));
      send_cmd(make_cmd(ACT_ERASE, 0, 255, 0, '0));
   endtask

   task automatic test_random_mix(input int count);
      for (int n = 0; n < count; n++) begin
         send_cmd(random_cmd());
         // let the table drain now and then
         if (n % 200 == 199) wait_for_drain();
      end
   endtask

   // Back-to-back beats with no idling on either side
   task automatic test_steady_stream(input int count);
      idle_on = 1'b0;
      for (int n = 0; n < count; n++) send_cmd(random_cmd());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      wait_for_drain();
      test_basic_ops();
      wait_for_drain();
      test_capacity();
      wait_for_drain();
      test_random_mix(800);
      wait_for_drain();
      test_steady_stream(150);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         log_mismatch("replies never returned", 32'(expected_replies.size()), '0);
      if (mismatch_total == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bvt_pkg.sv
src/bvt_ram.sv
src/bvt_ctrl.sv
src/bvt_dpath.sv
src/bounded_vector_table_top.sv
dv/bounded_vector_table_top_tb.sv
